FILE: src/pspm_pkg.sv
// Package for the per-source packet monitor: item, result and table entry types,
// protocol constants and saturating arithmetic helpers.
// No dependencies.
`default_nettype none

package pspm_pkg;

  // One input item: a parsed packet summary.
  typedef struct packed {
    logic        eth_header_fits;
    logic [15:0] eth_type;
    logic        ip_header_fits;
    logic [31:0] src_addr;
    logic [7:0]  ip_protocol;
    logic        l4_header_fits;
    logic [15:0] dst_port;
    logic [15:0] frame_len;
    logic [63:0] time_ns;
  } item_t;

  // One result item: verdict and the counters of the source.
  typedef struct packed {
    logic        verdict;
    logic        tracked;
    logic [63:0] src_bytes;
    logic [63:0] talker_bytes;
    logic [15:0] src_packets;
    logic [63:0] latency_ns;
    logic [63:0] jitter_ns;
    logic [31:0] web_count;
    logic [31:0] dns_count;
    logic [31:0] drop_count;
    logic [63:0] proto_bytes;
  } result_t;

  // One entry of the source table.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [63:0] bytes;
    logic [63:0] talker_bytes;
    logic [15:0] packets;
    logic [63:0] last_time;
    logic [63:0] last_latency;
    logic        has_latency;
    logic [31:0] web;
    logic [31:0] dns;
    logic [31:0] drops;
    logic        blocked;
  } entry_t;

  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] PORT_HTTP       = 16'd80;
  localparam logic [15:0] PORT_HTTPS      = 16'd443;
  localparam logic [15:0] PORT_DNS        = 16'd53;
  localparam logic [15:0] THRESHOLD_RESET = 16'd10;
  localparam logic [31:0] HASH_MULT       = 32'h9E37_79B1;
  localparam int unsigned NUM_PROTOCOLS   = 256;

  // Sum that sticks at the top of 64 bits.
  function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // Increment that sticks at the top of 32 bits.
  function automatic logic [31:0] inc_sat32(input logic [31:0] a);
    return (a == {32{1'b1}}) ? a : a + 32'd1;
  endfunction

endpackage

`default_nettype wire

FILE: src/pspm_hash.sv
// Bucket index unit: multiplicative hash of the source address, then the
// remainder by the bucket count (a mask, or a reciprocal multiplication otherwise).
// Depends on pspm_pkg.
`default_nettype none

module pspm_hash #(
  parameter int unsigned NUM_BUCKETS = 512,
  parameter int unsigned BKW         = 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [31:0]     key_i,
  output logic                 done_o,
  output logic [BKW-1:0]       bucket_o
);

  localparam bit              POW2  = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  // Rounded-up reciprocal, which gives the exact quotient of any 16-bit hash.
  localparam int unsigned     SHIFT = 16 + $clog2(NUM_BUCKETS);
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) /
                                      64'(NUM_BUCKETS);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic            stage_q, stage_d;
  logic [15:0]     h_q, h_d;
  logic [15:0]     quot_q, quot_d;
  logic [BKW-1:0]  bucket_q, bucket_d;
  logic [31:0]     prod;
  logic [33:0]     qprod;
  logic [31:0]     rem;

  // The hash keeps the upper half of the low product word.
  assign prod = key_i * pspm_pkg::HASH_MULT;

  // Quotient by reciprocal multiplication; the remainder is formed from the registered quotient.
  assign qprod = {18'd0, h_q} * 34'(RECIP);
  assign rem   = {16'd0, h_q} - (32'(quot_q) * 32'(NUM_BUCKETS));

  always_comb begin
    run_d    = run_q;
    done_d   = 1'b0;
    stage_d  = stage_q;
    h_d      = h_q;
    quot_d   = quot_q;
    bucket_d = bucket_q;
    if (start_i) begin
      run_d   = 1'b1;
      h_d     = prod[31:16];
      stage_d = 1'b0;
    end else if (run_q) begin
      if (POW2) begin
        bucket_d = h_q[BKW-1:0] & BKW'(NUM_BUCKETS - 1);
        done_d   = 1'b1;
        run_d    = 1'b0;
      end else if (!stage_q) begin
        quot_d  = 16'(qprod >> SHIFT);
        stage_d = 1'b1;
      end else begin
        bucket_d = rem[BKW-1:0];
        done_d   = 1'b1;
        run_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q  <= stage_d;
    h_q      <= h_d;
    quot_q   <= quot_d;
    bucket_q <= bucket_d;
  end

  assign done_o   = done_q;
  assign bucket_o = bucket_q;

`ifndef SYNTHESIS
  // A finished index always follows a running computation.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(run_q))
    else $error("bucket index done without a computation");
  // The index never leaves the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_q |-> (32'(bucket_q) < NUM_BUCKETS))
    else $error("bucket index out of range");
  // A new computation is not started on top of a running one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_q && !done_d |-> !start_i)
    else $error("hash restarted while running");
`endif

endmodule

`default_nettype wire

FILE: src/per_source_packet_monitor_core.sv
// Per-source packet monitor: top level with the source table memory, the
// protocol byte memory and the sequencer. Depends on pspm_pkg and pspm_hash.
// A non-IPv4 item, or one with a truncated Ethernet or IP header, gives its result
// in the cycle after start, with busy staying low. An IPv4 item passes through the
// hash, then one table read and one compare for each probed way, then the latency
// and write-back steps. The receiver cannot stall; one result per item. After reset
// a clearing pass over max(SOURCE_ENTRIES, 256) addresses holds busy high.
`default_nettype none

module per_source_packet_monitor_core #(
  parameter int unsigned SOURCE_ENTRIES = 2048,
  parameter int unsigned BUCKET_WAYS    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire pspm_pkg::item_t   item_i,
  output logic                   res_valid_o,
  output pspm_pkg::result_t      res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [15:0]       cfg_data_i
);

  localparam int unsigned NB    = SOURCE_ENTRIES / BUCKET_WAYS;
  localparam int unsigned BKW   = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned AW    = $clog2(SOURCE_ENTRIES);
  localparam int unsigned WW    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int unsigned CLR_N = (SOURCE_ENTRIES > pspm_pkg::NUM_PROTOCOLS) ?
                                  SOURCE_ENTRIES : pspm_pkg::NUM_PROTOCOLS;
  localparam int unsigned CW    = $clog2(CLR_N + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b000_0001,
    S_IDLE  = 7'b000_0010,
    S_HASH  = 7'b000_0100,
    S_RD    = 7'b000_1000,
    S_CHK   = 7'b001_0000,
    S_LAT   = 7'b010_0000,
    S_WB    = 7'b100_0000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        clr_q, clr_d;
  logic [15:0]          thr_q;
  pspm_pkg::item_t      in_q, in_d;
  logic                 l4ok_q, l4ok_d;
  logic [AW-1:0]        base_q, base_d;
  logic [WW-1:0]        way_q, way_d;
  logic                 free_found_q, free_found_d;
  logic [AW-1:0]        free_slot_q, free_slot_d;
  logic [AW-1:0]        slot_q, slot_d;
  logic                 tracked_q, tracked_d;
  logic                 fresh_q, fresh_d;
  pspm_pkg::entry_t     ent_q, ent_d;
  pspm_pkg::entry_t     nent_q, nent_d;
  logic [63:0]          lat_q, lat_d;
  logic [63:0]          prev_lat_q, prev_lat_d;
  logic                 has_prev_q, has_prev_d;
  logic                 drop_q, drop_d;
  logic                 upd_q, upd_d;
  pspm_pkg::result_t    res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  // Memories and their ports.
  pspm_pkg::entry_t     ent_mem [SOURCE_ENTRIES];
  logic [63:0]          proto_mem [pspm_pkg::NUM_PROTOCOLS];
  pspm_pkg::entry_t     ent_rd_q;
  logic [63:0]          proto_rd_q;
  logic [AW-1:0]        ent_raddr;
  logic                 ent_we;
  logic [AW-1:0]        ent_waddr;
  pspm_pkg::entry_t     ent_wdata;
  logic                 proto_we;
  logic [7:0]           proto_waddr;
  logic [63:0]          proto_wdata;

  logic                 accept;
  logic                 is_ip;
  logic                 hash_done;
  logic [BKW-1:0]       bucket;
  logic [63:0]          len64;
  logic                 hit;
  logic                 last_way;
  logic                 drop_c;
  logic                 upd_c;
  logic                 web_hit;
  logic                 dns_hit;
  logic [63:0]          lat_c;
  logic [63:0]          jitter_c;
  logic [63:0]          proto_new;

  assign accept = start && !busy;
  assign is_ip  = item_i.eth_header_fits && item_i.ip_header_fits &&
                  (item_i.eth_type == pspm_pkg::ETHERTYPE_IPV4);

  pspm_hash #(
    .NUM_BUCKETS (NB),
    .BKW         (BKW)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && is_ip),
    .key_i    (item_i.src_addr),
    .done_o   (hash_done),
    .bucket_o (bucket)
  );

  // Source table: one write port, one registered read port.
  assign ent_raddr = base_q + AW'(way_q);
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  // Protocol byte table, read by the protocol of the item in flight.
  always_ff @(posedge clk_i) begin
    if (proto_we) begin
      proto_mem[proto_waddr] <= proto_wdata;
    end
    proto_rd_q <= proto_mem[in_q.ip_protocol];
  end

  // Per-item arithmetic.
  assign len64   = 64'(in_q.frame_len);
  assign hit     = ent_rd_q.valid && (ent_rd_q.key == in_q.src_addr);
  assign last_way = (way_q == WW'(BUCKET_WAYS - 1));
  assign drop_c  = tracked_q && !fresh_q && (ent_q.packets >= thr_q);
  assign upd_c   = !drop_c && l4ok_q;
  assign web_hit = (in_q.ip_protocol == pspm_pkg::PROTO_TCP) &&
                   ((in_q.dst_port == pspm_pkg::PORT_HTTP) ||
                    (in_q.dst_port == pspm_pkg::PORT_HTTPS));
  assign dns_hit = (in_q.ip_protocol == pspm_pkg::PROTO_UDP) &&
                   (in_q.dst_port == pspm_pkg::PORT_DNS);
  assign lat_c   = in_q.time_ns - ent_q.last_time;
  assign jitter_c = !has_prev_q ? 64'd0 :
                    (lat_q > prev_lat_q) ? (lat_q - prev_lat_q) : (prev_lat_q - lat_q);
  assign proto_new = upd_q ? pspm_pkg::add_sat64(proto_rd_q, len64) : proto_rd_q;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    in_d         = in_q;
    l4ok_d       = l4ok_q;
    base_d       = base_q;
    way_d        = way_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    slot_d       = slot_q;
    tracked_d    = tracked_q;
    fresh_d      = fresh_q;
    ent_d        = ent_q;
    nent_d       = nent_q;
    lat_d        = lat_q;
    prev_lat_d   = prev_lat_q;
    has_prev_d   = has_prev_q;
    drop_d       = drop_q;
    upd_d        = upd_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = slot_q;
    ent_wdata    = nent_q;
    proto_we     = 1'b0;
    proto_waddr  = in_q.ip_protocol;
    proto_wdata  = proto_new;

    case (state_q)
      S_CLEAR: begin
        ent_we          = (clr_q < CW'(SOURCE_ENTRIES));
        ent_waddr       = clr_q[AW-1:0];
        ent_wdata       = '0;
        proto_we        = (clr_q < CW'(pspm_pkg::NUM_PROTOCOLS));
        proto_waddr     = clr_q[7:0];
        proto_wdata     = '0;
        clr_d           = clr_q + CW'(1);
        if (clr_q == CW'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          in_d   = item_i;
          l4ok_d = !(((item_i.ip_protocol == pspm_pkg::PROTO_TCP) ||
                      (item_i.ip_protocol == pspm_pkg::PROTO_UDP)) &&
                     !item_i.l4_header_fits);
          if (is_ip) begin
            state_d = S_HASH;
          end else begin
            res_d       = '0;
            res_valid_d = 1'b1;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          base_d       = AW'(bucket) * AW'(BUCKET_WAYS);
          way_d        = '0;
          free_found_d = 1'b0;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        ent_d = ent_rd_q;
        if (hit) begin
          slot_d    = ent_raddr;
          tracked_d = 1'b1;
          fresh_d   = 1'b0;
          state_d   = S_LAT;
        end else begin
          if (!ent_rd_q.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = ent_raddr;
          end
          if (last_way) begin
            tracked_d = free_found_q || !ent_rd_q.valid;
            fresh_d   = 1'b1;
            slot_d    = free_found_q ? free_slot_q : ent_raddr;
            state_d   = S_LAT;
          end else begin
            way_d   = way_q + WW'(1);
            state_d = S_RD;
          end
        end
      end
      S_LAT: begin
        drop_d     = drop_c;
        upd_d      = upd_c;
        prev_lat_d = ent_q.last_latency;
        has_prev_d = tracked_q && !fresh_q && !drop_c && ent_q.has_latency;
        lat_d      = (tracked_q && !fresh_q && !drop_c) ? lat_c : 64'd0;
        if (fresh_q) begin
          // A new source starts its entry from this packet.
          nent_d              = '0;
          nent_d.valid        = 1'b1;
          nent_d.key          = in_q.src_addr;
          nent_d.bytes        = len64;
          nent_d.packets      = 16'd1;
          nent_d.last_time    = in_q.time_ns;
          nent_d.talker_bytes = l4ok_q ? len64 : 64'd0;
          nent_d.web          = 32'(l4ok_q && web_hit);
          nent_d.dns          = 32'(l4ok_q && dns_hit);
        end else begin
          nent_d       = ent_q;
          nent_d.bytes = pspm_pkg::add_sat64(ent_q.bytes, len64);
          if (drop_c) begin
            nent_d.blocked = 1'b1;
            nent_d.drops   = pspm_pkg::inc_sat32(ent_q.drops);
          end else begin
            nent_d.packets      = ent_q.packets + 16'd1;
            nent_d.last_latency = lat_c;
            nent_d.has_latency  = 1'b1;
            nent_d.last_time    = in_q.time_ns;
          end
          if (upd_c) begin
            if (web_hit) begin
              nent_d.web = pspm_pkg::inc_sat32(ent_q.web);
            end
            if (dns_hit) begin
              nent_d.dns = pspm_pkg::inc_sat32(ent_q.dns);
            end
            nent_d.talker_bytes = pspm_pkg::add_sat64(ent_q.talker_bytes, len64);
          end
        end
        state_d = S_WB;
      end
      S_WB: begin
        ent_we             = tracked_q;
        proto_we           = upd_q;
        res_d              = '0;
        res_d.verdict      = drop_q;
        res_d.proto_bytes  = proto_new;
        if (tracked_q) begin
          res_d.tracked      = 1'b1;
          res_d.src_bytes    = nent_q.bytes;
          res_d.talker_bytes = nent_q.talker_bytes;
          res_d.src_packets  = nent_q.packets;
          res_d.latency_ns   = lat_q;
          res_d.jitter_ns    = jitter_c;
          res_d.web_count    = nent_q.web;
          res_d.dns_count    = nent_q.dns;
          res_d.drop_count   = nent_q.drops;
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      thr_q       <= pspm_pkg::THRESHOLD_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_q         <= in_d;
    l4ok_q       <= l4ok_d;
    base_q       <= base_d;
    way_q        <= way_d;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    slot_q       <= slot_d;
    tracked_q    <= tracked_d;
    fresh_q      <= fresh_d;
    ent_q        <= ent_d;
    nent_q       <= nent_d;
    lat_q        <= lat_d;
    prev_lat_q   <= prev_lat_d;
    has_prev_q   <= has_prev_d;
    drop_q       <= drop_d;
    upd_q        <= upd_d;
    res_q        <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // A dropped packet always belongs to a tracked source.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_valid_q && res_q.verdict |-> res_q.tracked)
    else $error("drop verdict on an untracked source");
  // A result follows either a write-back or a short-cut item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_valid_q |-> ($past(state_q) == S_WB) || ($past(state_q) == S_IDLE))
    else $error("result outside write-back");
  // No result appears during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_CLEAR) |-> !res_valid_q)
    else $error("result during table clearing");
  // Table writes outside clearing only happen at write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ent_we |-> (state_q == S_WB) || (state_q == S_CLEAR))
    else $error("unexpected table write");
`endif

endmodule

`default_nettype wire

FILE: tb/per_source_packet_monitor_core_tb.sv
// Self-checking testbench for the per-source packet monitor core: a clocked driver and
// monitor, with a predictor that keeps its own source table, protocol byte table and threshold.
// Depends on pspm_pkg and on the per_source_packet_monitor_core RTL.
`default_nettype none

module per_source_packet_monitor_core_tb;

  localparam int unsigned TABLE_SIZE  = 2048;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned BUCKETS     = TABLE_SIZE / WAYS;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned RANDOM_PER_PHASE = 247;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  pspm_pkg::item_t   item_i = '0;
  logic              res_valid_o;
  pspm_pkg::result_t res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [15:0]       cfg_data_i = '0;

  per_source_packet_monitor_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: source table, protocol byte totals and the threshold.
  pspm_pkg::entry_t  src_table [TABLE_SIZE];
  logic [63:0]       proto_totals [256];
  logic [15:0]       threshold = pspm_pkg::THRESHOLD_RESET;

  pspm_pkg::item_t   packets_to_send [$];
  pspm_pkg::result_t expected_results [$];
  int unsigned       gap_left = 0;
  int unsigned       cycle_count = 0;
  int unsigned       mismatches = 0;
  logic [63:0]       clock_ns;
  logic [31:0]       pool [$];

  function automatic logic [63:0] sum_clamped(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] count_up(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic int unsigned bucket_of(input logic [31:0] addr);
    logic [31:0] prod;
    prod = addr * pspm_pkg::HASH_MULT;
    return int'(prod[31:16]) % BUCKETS;
  endfunction

  // Works out the result of one packet and updates the predicted tables.
  function automatic pspm_pkg::result_t monitor_predict(input pspm_pkg::item_t p);
    pspm_pkg::result_t r;
    int                slot;
    int unsigned       base;
    logic              fresh, drop, l4_ok;
    logic [63:0]       gap_ns;
    r = '0;
    slot = -1;
    fresh = 1'b0;
    drop = 1'b0;
    if (!p.eth_header_fits || p.eth_type != pspm_pkg::ETHERTYPE_IPV4 ||
        !p.ip_header_fits) return r;
    l4_ok = !((p.ip_protocol == pspm_pkg::PROTO_TCP || p.ip_protocol == pspm_pkg::PROTO_UDP) &&
              !p.l4_header_fits);
    base = bucket_of(p.src_addr) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (src_table[base + w].valid) begin
        if (src_table[base + w].key == p.src_addr && !(slot >= 0 && !fresh)) begin
          slot = base + w;
          fresh = 1'b0;
        end
      end else if (slot < 0) begin
        slot = base + w;
        fresh = 1'b1;
      end
    end
    if (slot >= 0) begin
      if (fresh) begin
        src_table[slot] = '0;
        src_table[slot].valid = 1'b1;
        src_table[slot].key = p.src_addr;
        src_table[slot].bytes = 64'(p.frame_len);
        src_table[slot].packets = 16'd1;
        src_table[slot].last_time = p.time_ns;
      end else begin
        src_table[slot].bytes = sum_clamped(src_table[slot].bytes, 64'(p.frame_len));
        if (src_table[slot].packets >= threshold) begin
          drop = 1'b1;
          src_table[slot].blocked = 1'b1;
          src_table[slot].drops = count_up(src_table[slot].drops);
        end else begin
          src_table[slot].packets = src_table[slot].packets + 16'd1;
          gap_ns = p.time_ns - src_table[slot].last_time;
          r.latency_ns = gap_ns;
          if (src_table[slot].has_latency)
            r.jitter_ns = (gap_ns > src_table[slot].last_latency) ?
                          gap_ns - src_table[slot].last_latency :
                          src_table[slot].last_latency - gap_ns;
          src_table[slot].last_latency = gap_ns;
          src_table[slot].has_latency = 1'b1;
          src_table[slot].last_time = p.time_ns;
        end
      end
      if (!drop && l4_ok) begin
        if (p.ip_protocol == pspm_pkg::PROTO_TCP &&
            (p.dst_port == pspm_pkg::PORT_HTTP || p.dst_port == pspm_pkg::PORT_HTTPS))
          src_table[slot].web = count_up(src_table[slot].web);
        if (p.ip_protocol == pspm_pkg::PROTO_UDP && p.dst_port == pspm_pkg::PORT_DNS)
          src_table[slot].dns = count_up(src_table[slot].dns);
        src_table[slot].talker_bytes = sum_clamped(src_table[slot].talker_bytes,
                                                   64'(p.frame_len));
      end
      r.tracked = 1'b1;
      r.src_bytes = src_table[slot].bytes;
      r.talker_bytes = src_table[slot].talker_bytes;
      r.src_packets = src_table[slot].packets;
      r.web_count = src_table[slot].web;
      r.dns_count = src_table[slot].dns;
      r.drop_count = src_table[slot].drops;
    end
    if (!drop && l4_ok)
      proto_totals[p.ip_protocol] = sum_clamped(proto_totals[p.ip_protocol], 64'(p.frame_len));
    r.verdict = drop;
    r.proto_bytes = proto_totals[p.ip_protocol];
    return r;
  endfunction

  // A well-formed IPv4 packet from the given source at the given time.
  function automatic pspm_pkg::item_t ipv4_packet(input logic [31:0] src,
                                                  input logic [7:0] proto,
                                                  input logic [15:0] port,
                                                  input logic [63:0] at_ns);
    pspm_pkg::item_t p;
    p = '0;
    p.eth_header_fits = 1'b1;
    p.eth_type = pspm_pkg::ETHERTYPE_IPV4;
    p.ip_header_fits = 1'b1;
    p.src_addr = src;
    p.ip_protocol = proto;
    p.l4_header_fits = 1'b1;
    p.dst_port = port;
    p.frame_len = 16'($urandom_range(0, 65535));
    p.time_ns = at_ns;
    return p;
  endfunction

  function automatic logic [31:0] addr_in_bucket(input int unsigned b);
    logic [31:0] a;
    do a = $urandom(); while (bucket_of(a) != b);
    return a;
  endfunction

  // Mostly sources from a small pool, so that thresholds, drops and full buckets are reached.
  function automatic pspm_pkg::item_t random_packet();
    pspm_pkg::item_t p;
    logic [7:0]      proto;
    logic [15:0]     port;
    logic [31:0]     src;
    case ($urandom_range(0, 5))
      0, 1: proto = pspm_pkg::PROTO_TCP;
      2, 3: proto = pspm_pkg::PROTO_UDP;
      4:    proto = PROTO_ICMP;
      default: proto = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 4))
      0: port = pspm_pkg::PORT_HTTP;
      1: port = pspm_pkg::PORT_HTTPS;
      2: port = pspm_pkg::PORT_DNS;
      default: port = 16'($urandom_range(0, 65535));
    endcase
    src = ($urandom_range(0, 19) == 0) ? $urandom() : pool[$urandom_range(0, pool.size() - 1)];
    if ($urandom_range(0, 49) == 0) clock_ns = clock_ns - 64'($urandom_range(1, 100000));
    else clock_ns = clock_ns + 64'($urandom_range(0, 20000));
    p = ipv4_packet(src, proto, port, clock_ns);
    if ($urandom_range(0, 9) == 0) p.l4_header_fits = 1'b0;
    // Some noise: broken or non-IPv4 frames with random content.
    case ($urandom_range(0, 19))
      0: p.eth_header_fits = 1'b0;
      1: p.eth_type = 16'($urandom_range(0, 65535));
      2: p.ip_header_fits = 1'b0;
      default: ;
    endcase
    return p;
  endfunction

  // A fresh set of sources: six share one bucket, so the last two find it full.
  task automatic build_pool();
    int unsigned b;
    pool.delete();
    b = $urandom_range(0, BUCKETS - 1);
    for (int k = 0; k < 6; k++) pool.push_back(addr_in_bucket(b));
    for (int k = 0; k < 18; k++) pool.push_back($urandom());
  endtask

  // Driver: holds each item until it is taken, then waits a random gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_results.push_back(monitor_predict(item_i));
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (gap_left == 0 && packets_to_send.size() > 0) begin
        item_i <= packets_to_send.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
    end
  endtask

  // Monitor: every result strobe is checked against the oldest expectation.
  always @(posedge clk_i) begin
    pspm_pkg::result_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, res_o);
      end else begin
        e = expected_results.pop_front();
        check_field("verdict", 64'(e.verdict), 64'(res_o.verdict));
        check_field("tracked", 64'(e.tracked), 64'(res_o.tracked));
        check_field("src_bytes", e.src_bytes, res_o.src_bytes);
        check_field("talker_bytes", e.talker_bytes, res_o.talker_bytes);
        check_field("src_packets", 64'(e.src_packets), 64'(res_o.src_packets));
        check_field("latency_ns", e.latency_ns, res_o.latency_ns);
        check_field("jitter_ns", e.jitter_ns, res_o.jitter_ns);
        check_field("web_count", 64'(e.web_count), 64'(res_o.web_count));
        check_field("dns_count", 64'(e.dns_count), 64'(res_o.dns_count));
        check_field("drop_count", 64'(e.drop_count), 64'(res_o.drop_count));
        check_field("proto_bytes", e.proto_bytes, res_o.proto_bytes);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (packets_to_send.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    pspm_pkg::item_t p;
    logic [31:0]     a, b2;
    logic [15:0]     settings [6];
    for (int k = 0; k < TABLE_SIZE; k++) src_table[k] = '0;
    for (int k = 0; k < 256; k++) proto_totals[k] = '0;
    settings = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd10, 16'd1};
    settings[3] = 16'($urandom_range(2, 40));
    clock_ns = {$urandom(), $urandom()};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset threshold.
    a = $urandom();
    p = ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd0);
    p.eth_header_fits = 1'b0;                          packets_to_send.push_back(p);
    p = ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd0);
    p.eth_type = 16'hFFFF;                             packets_to_send.push_back(p);
    p.eth_type = 16'h0000;                             packets_to_send.push_back(p);
    p = ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd0);
    p.ip_header_fits = 1'b0;                           packets_to_send.push_back(p);
    p = ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd0);
    p.frame_len = 16'd0;                               packets_to_send.push_back(p);
    p = ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTPS, 64'd1000);
    p.frame_len = 16'hFFFF;                            packets_to_send.push_back(p);
    packets_to_send.push_back(ipv4_packet(a, pspm_pkg::PROTO_UDP, pspm_pkg::PORT_DNS, 64'd1500));
    p = ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd1700);
    p.l4_header_fits = 1'b0;                           packets_to_send.push_back(p);
    p = ipv4_packet(a, 8'hFF, pspm_pkg::PORT_DNS, 64'd900);
    p.l4_header_fits = 1'b0;                           packets_to_send.push_back(p);
    packets_to_send.push_back(ipv4_packet(a, pspm_pkg::PROTO_UDP, 16'hFFFF, '1));
    packets_to_send.push_back(ipv4_packet(a, PROTO_ICMP, 16'd0, 64'd5));
    packets_to_send.push_back(ipv4_packet(a, pspm_pkg::PROTO_UDP, pspm_pkg::PORT_DNS, 64'd10));
    packets_to_send.push_back(ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd20));
    packets_to_send.push_back(ipv4_packet(a, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTP, 64'd30));
    b2 = 32'hFFFF_FFFF;
    packets_to_send.push_back(ipv4_packet(b2, 8'd0, 16'd0, '1));
    packets_to_send.push_back(ipv4_packet(32'd0, pspm_pkg::PROTO_TCP, pspm_pkg::PORT_HTTPS,
                                          64'd0));
    // Six sources in one bucket: the last two find it full, but still count protocol bytes.
    build_pool();
    for (int k = 0; k < 6; k++)
      packets_to_send.push_back(ipv4_packet(pool[k], pspm_pkg::PROTO_UDP, pspm_pkg::PORT_DNS,
                                            64'(k)));

    // Random phases; all but the first run under a new threshold with a fresh set of sources.
    for (int ph = 0; ph <= 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_threshold(settings[ph - 1]);
        build_pool();
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) packets_to_send.push_back(random_packet());
    end

    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/pspm_pkg.sv
src/pspm_hash.sv
src/per_source_packet_monitor_core.sv
tb/per_source_packet_monitor_core_tb.sv
